### sv/slwf_pkg.sv
// ----------------------------------------------------------------------------
// slwf_pkg
// Shared types and constants of the serial display window fill engine.
// ----------------------------------------------------------------------------
package slwf_pkg;

    // coordinate bits taken from the rectangle corners
    localparam int COORD_BITS = 16;
    localparam int WORD_W     = 16;

    // request actions
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_FILL = 2'd1;
    localparam logic [1:0] ACT_CMD  = 2'd2;
    localparam logic [1:0] ACT_DATA = 2'd3;

    // configuration register indexes
    localparam logic CFG_ORIENTATION = 1'b0;
    localparam logic CFG_OFFSET      = 1'b1;

    localparam logic [7:0] OFFSET_RESET = 8'd24;

    // display commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // shift ticks per byte, the gap tick follows
    localparam logic [4:0] BYTE_TICKS = 5'd16;

    // sequencer phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SINGLE = 4'd1;
    localparam logic [3:0] PH_CASET  = 4'd2;
    localparam logic [3:0] PH_COL0   = 4'd3;
    localparam logic [3:0] PH_COL1   = 4'd4;
    localparam logic [3:0] PH_RASET  = 4'd5;
    localparam logic [3:0] PH_ROW0   = 4'd6;
    localparam logic [3:0] PH_ROW1   = 4'd7;
    localparam logic [3:0] PH_RAMWR  = 4'd8;
    localparam logic [3:0] PH_PIXEL  = 4'd9;

    // one request
    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] x_start;
        logic [WORD_W-1:0] y_start;
        logic [WORD_W-1:0] x_end;
        logic [WORD_W-1:0] y_end;
        logic [WORD_W-1:0] color;
        logic [7:0]        byte_value;
    } t_item;

    // pin states of one tick
    typedef struct packed {
        logic chip_select_n;
        logic serial_clock;
        logic serial_data;
        logic reg_select;
        logic busy_res;
        logic rejected;
    } t_pins;

endpackage

### sv/spi_lcd_window_fill_engine_unit.sv
// ----------------------------------------------------------------------------
// spi_lcd_window_fill_engine_unit
// Serial display link engine: single bytes and rectangle fills.
// ----------------------------------------------------------------------------
// Every request is one tick of the serial link and gives one set of pin
// states. The block takes one request per clock while the result side does
// not stall; an accepted request is held in the input register, then worked
// into the result register, which drives the outputs. While a result is
// stalled the input register still takes one more request, then the request
// side stalls too. A byte takes 17 ticks (16 shift ticks, one chip-select-high
// gap); a fill takes 17 ticks per byte for 11 window and command bytes plus
// two bytes per pixel. Requests other than a plain tick that arrive while busy
// are flagged as rejected. The user must write configuration only while no
// request or result is in flight; the block itself does not enforce it.
module spi_lcd_window_fill_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_x_start,
    input  logic [15:0] i_y_start,
    input  logic [15:0] i_x_end,
    input  logic [15:0] i_y_end,
    input  logic [15:0] i_color,
    input  logic [7:0]  i_byte_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_chip_select_n,
    output logic        o_serial_clock,
    output logic        o_serial_data,
    output logic        o_reg_select,
    output logic        o_busy_res,
    output logic        o_rejected
);
    import slwf_pkg::*;

    t_item w_in_item;
    t_item w_stage_item;
    logic  w_stage_valid;
    logic  w_take;
    t_pins w_pins;

    // request bundle
    assign w_in_item = '{action: i_action, x_start: i_x_start, y_start: i_y_start,
                         x_end: i_x_end, y_end: i_y_end, color: i_color,
                         byte_value: i_byte_value};

    slwf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item),
        .i_take  (w_take)
    );

    slwf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pins      (w_pins)
    );

    // pin outputs
    assign o_chip_select_n = w_pins.chip_select_n;
    assign o_serial_clock  = w_pins.serial_clock;
    assign o_serial_data   = w_pins.serial_data;
    assign o_reg_select    = w_pins.reg_select;
    assign o_busy_res      = w_pins.busy_res;
    assign o_rejected      = w_pins.rejected;

endmodule

### sv/slwf_in_stage.sv
// ----------------------------------------------------------------------------
// slwf_in_stage
// Input register: holds one request until the engine takes it.
// ----------------------------------------------------------------------------
module slwf_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  slwf_pkg::t_item i_item,
    output logic           o_valid,
    output slwf_pkg::t_item o_item,
    input  logic           i_take
);
    import slwf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/slwf_engine.sv
// ----------------------------------------------------------------------------
// slwf_engine
// Byte sequencer, bit shifter and result register of the fill engine.
// ----------------------------------------------------------------------------
module slwf_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_valid,
    input  slwf_pkg::t_item i_item,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output slwf_pkg::t_pins o_pins
);
    import slwf_pkg::*;

    // configuration
    logic [1:0]        r_orient;
    logic [7:0]        r_offset;

    // sequencer state
    logic [3:0]        r_phase,  n_phase;
    logic [4:0]        r_tick,   n_tick;
    logic [7:0]        r_shift,  n_shift;
    logic              r_cmd,    n_cmd;
    logic [WORD_W-1:0] r_col,    n_col;
    logic [WORD_W-1:0] r_row,    n_row;
    logic [WORD_W-1:0] r_win0,   n_win0;
    logic [WORD_W-1:0] r_win1,   n_win1;
    logic [WORD_W-1:0] r_win2,   n_win2;
    logic [WORD_W-1:0] r_win3,   n_win3;
    logic [WORD_W-1:0] r_color,  n_color;
    logic              r_lnb,    n_lnb;

    // result register
    logic              r_out_valid;
    t_pins             r_pins,   n_pins;

    // fill setup values
    logic [WORD_W-1:0] w_xs, w_ys, w_xe, w_ye, w_ox, w_oy, w_span;

    assign o_take = i_valid && (!r_out_valid || !i_out_stall);

    // masked corners and offsets
    always_comb begin
        w_xs = WORD_W'(i_item.x_start[COORD_BITS-1:0]);
        w_ys = WORD_W'(i_item.y_start[COORD_BITS-1:0]);
        w_xe = WORD_W'(i_item.x_end[COORD_BITS-1:0]);
        w_ye = WORD_W'(i_item.y_end[COORD_BITS-1:0]);
        w_ox = (r_orient < 2'd2) ? WORD_W'(r_offset) : '0;
        w_oy = (r_orient < 2'd2) ? '0 : WORD_W'(r_offset);
        w_span = r_win1 - r_win0 + WORD_W'(1);
    end

    // next state and pins of one tick
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_cmd   = r_cmd;
        n_col   = r_col;
        n_row   = r_row;
        n_win0  = r_win0;
        n_win1  = r_win1;
        n_win2  = r_win2;
        n_win3  = r_win3;
        n_color = r_color;
        n_lnb   = r_lnb;
        n_pins  = '{chip_select_n: 1'b1, serial_clock: 1'b1, serial_data: 1'b0,
                    reg_select: 1'b1, busy_res: 1'b0, rejected: 1'b0};

        // request handling
        if (r_phase != PH_IDLE) begin
            n_pins.rejected = (i_item.action != ACT_TICK);
        end else if (i_item.action inside {ACT_CMD, ACT_DATA}) begin
            n_shift = i_item.byte_value;
            n_cmd   = (i_item.action == ACT_CMD);
            n_tick  = '0;
            n_phase = PH_SINGLE;
        end else if (i_item.action == ACT_FILL) begin
            n_win0  = w_xs + w_ox;
            n_win1  = w_xe - WORD_W'(1) + w_ox;
            n_win2  = w_ys + w_oy;
            n_win3  = w_ye - WORD_W'(1) + w_oy;
            n_color = i_item.color;
            n_col   = (w_xe > w_xs) ? w_xe - w_xs : '0;
            n_row   = (w_ye > w_ys) ? w_ye - w_ys : '0;
            n_lnb   = 1'b0;
            n_shift = CMD_CASET;
            n_cmd   = 1'b1;
            n_tick  = '0;
            n_phase = PH_CASET;
        end

        // shift tick or gap tick
        if (n_phase != PH_IDLE) begin
            n_pins.busy_res = 1'b1;
            if (n_tick < BYTE_TICKS) begin
                n_pins.chip_select_n = 1'b0;
                n_pins.serial_clock  = n_tick[0];
                n_pins.serial_data   = n_shift[3'd7 - n_tick[3:1]];
                n_pins.reg_select    = !n_cmd;
                n_tick = n_tick + 5'd1;
            end else begin
                // gap tick: the next byte of the sequence is loaded, or the sequence ends
                n_tick = '0;
                case (r_phase)
                    PH_CASET: begin
                        n_phase = PH_COL0;
                        n_lnb   = 1'b0;
                        n_shift = r_win0[15:8];
                        n_cmd   = 1'b0;
                    end
                    PH_COL0: begin
                        if (!r_lnb) begin
                            n_shift = r_win0[7:0];
                            n_cmd   = 1'b0;
                            n_lnb   = 1'b1;
                        end else begin
                            n_lnb   = 1'b0;
                            n_phase = PH_COL1;
                            n_shift = r_win1[15:8];
                            n_cmd   = 1'b0;
                        end
                    end
                    PH_COL1: begin
                        if (!r_lnb) begin
                            n_shift = r_win1[7:0];
                            n_cmd   = 1'b0;
                            n_lnb   = 1'b1;
                        end else begin
                            n_lnb   = 1'b0;
                            n_phase = PH_RASET;
                            n_shift = CMD_RASET;
                            n_cmd   = 1'b1;
                        end
                    end
                    PH_RASET: begin
                        n_phase = PH_ROW0;
                        n_lnb   = 1'b0;
                        n_shift = r_win2[15:8];
                        n_cmd   = 1'b0;
                    end
                    PH_ROW0: begin
                        if (!r_lnb) begin
                            n_shift = r_win2[7:0];
                            n_cmd   = 1'b0;
                            n_lnb   = 1'b1;
                        end else begin
                            n_lnb   = 1'b0;
                            n_phase = PH_ROW1;
                            n_shift = r_win3[15:8];
                            n_cmd   = 1'b0;
                        end
                    end
                    PH_ROW1: begin
                        if (!r_lnb) begin
                            n_shift = r_win3[7:0];
                            n_cmd   = 1'b0;
                            n_lnb   = 1'b1;
                        end else begin
                            n_lnb   = 1'b0;
                            n_phase = PH_RAMWR;
                            n_shift = CMD_RAMWR;
                            n_cmd   = 1'b1;
                        end
                    end
                    PH_RAMWR: begin
                        // empty rectangle ends after the window and the RAMWR command
                        if (r_col == '0 || r_row == '0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_PIXEL;
                            n_lnb   = 1'b0;
                            n_shift = r_color[15:8];
                            n_cmd   = 1'b0;
                        end
                    end
                    PH_PIXEL: begin
                        if (!r_lnb) begin
                            n_shift = r_color[7:0];
                            n_cmd   = 1'b0;
                            n_lnb   = 1'b1;
                        end else begin
                            n_lnb = 1'b0;
                            n_col = r_col - WORD_W'(1);
                            if (n_col == '0 && r_row == WORD_W'(1)) begin
                                n_row   = '0;
                                n_phase = PH_IDLE;
                            end else begin
                                if (n_col == '0) begin
                                    n_row = r_row - WORD_W'(1);
                                    n_col = w_span;
                                end
                                n_shift = r_color[15:8];
                                n_cmd   = 1'b0;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= '0;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIENTATION: r_orient <= i_cfg_data[1:0];
                CFG_OFFSET:      r_offset <= i_cfg_data;
                default:         r_offset <= r_offset;
            endcase
        end
    end

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_shift <= '0;
            r_cmd   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_lnb   <= 1'b0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_cmd   <= n_cmd;
            r_col   <= n_col;
            r_row   <= n_row;
            r_lnb   <= n_lnb;
        end
    end

    // saved window and colour
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_win0  <= n_win0;
            r_win1  <= n_win1;
            r_win2  <= n_win2;
            r_win3  <= n_win3;
            r_color <= n_color;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pins <= n_pins;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pins      = r_pins;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial display window fill engine: byte and
// rectangle fill requests are ticked through the link, every tick's pin
// states are predicted and compared, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slwf_pkg::*;

    // predicted link engine and the queue of pin states still to come
    class pin_scoreboard;
        logic [1:0]  orient;
        logic [7:0]  offset;
        logic [3:0]  phase;
        logic [4:0]  tick_in_byte;
        logic [7:0]  shreg;
        logic        cmd_mode;
        logic [15:0] cols_left;
        logic [15:0] rows_left;
        logic [15:0] win [4];
        logic [15:0] pix_color;
        logic        low_half;
        t_pins       expected_pins [$];
        int          errors;
        int          checked;

        function new();
            orient       = 2'd0;
            offset       = OFFSET_RESET;
            phase        = PH_IDLE;
            tick_in_byte = '0;
            shreg        = '0;
            cmd_mode     = 1'b0;
            cols_left    = '0;
            rows_left    = '0;
            foreach (win[i]) win[i] = '0;
            pix_color    = '0;
            low_half     = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void set_register(logic idx, logic [7:0] val);
            if (idx == CFG_ORIENTATION) orient = val[1:0];
            else offset = val;
        endfunction

        function void load_byte(logic [7:0] b, logic is_cmd);
            shreg        = b;
            cmd_mode     = is_cmd;
            tick_in_byte = '0;
        endfunction

        // high byte was sent: load the low one, or report the word as done
        function bit word_step(logic [15:0] w);
            if (!low_half) begin
                load_byte(w[7:0], 1'b0);
                low_half = 1'b1;
                return 1'b0;
            end
            low_half = 1'b0;
            return 1'b1;
        endfunction

        // pick the next byte of a fill sequence
        function void advance();
            case (phase)
                PH_CASET: begin
                    phase    = PH_COL0;
                    low_half = 1'b0;
                    load_byte(win[0][15:8], 1'b0);
                end
                PH_COL0: begin
                    if (word_step(win[0])) begin
                        phase = PH_COL1;
                        load_byte(win[1][15:8], 1'b0);
                    end
                end
                PH_COL1: begin
                    if (word_step(win[1])) begin
                        phase = PH_RASET;
                        load_byte(CMD_RASET, 1'b1);
                    end
                end
                PH_RASET: begin
                    phase    = PH_ROW0;
                    low_half = 1'b0;
                    load_byte(win[2][15:8], 1'b0);
                end
                PH_ROW0: begin
                    if (word_step(win[2])) begin
                        phase = PH_ROW1;
                        load_byte(win[3][15:8], 1'b0);
                    end
                end
                PH_ROW1: begin
                    if (word_step(win[3])) begin
                        phase = PH_RAMWR;
                        load_byte(CMD_RAMWR, 1'b1);
                    end
                end
                PH_RAMWR: begin
                    if (cols_left == 0 || rows_left == 0) begin
                        phase = PH_IDLE;
                    end else begin
                        phase    = PH_PIXEL;
                        low_half = 1'b0;
                        load_byte(pix_color[15:8], 1'b0);
                    end
                end
                PH_PIXEL: begin
                    if (word_step(pix_color)) begin
                        cols_left = cols_left - 16'd1;
                        if (cols_left == 0) begin
                            rows_left = rows_left - 16'd1;
                            if (rows_left == 0) begin
                                phase = PH_IDLE;
                                return;
                            end
                            cols_left = win[1] - win[0] + 16'd1;
                        end
                        load_byte(pix_color[15:8], 1'b0);
                    end
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        // one accepted request: one tick of the link and its pin states
        function void note_request(t_item it);
            t_pins       p;
            logic [15:0] cmask;
            logic [15:0] sx, sy, xs, ys, xe, ye;
            cmask = 16'((32'd1 << COORD_BITS) - 1);
            p = '0;
            p.chip_select_n = 1'b1;
            p.serial_clock  = 1'b1;
            p.reg_select    = 1'b1;

            if (phase != PH_IDLE) begin
                if (it.action != ACT_TICK) p.rejected = 1'b1;
            end else if (it.action == ACT_CMD || it.action == ACT_DATA) begin
                load_byte(it.byte_value, it.action == ACT_CMD);
                phase = PH_SINGLE;
            end else if (it.action == ACT_FILL) begin
                xs = it.x_start & cmask;
                ys = it.y_start & cmask;
                xe = it.x_end & cmask;
                ye = it.y_end & cmask;
                sx = (orient < 2) ? {8'd0, offset} : 16'd0;
                sy = (orient < 2) ? 16'd0 : {8'd0, offset};
                win[0]    = xs + sx;
                win[1]    = xe - 16'd1 + sx;
                win[2]    = ys + sy;
                win[3]    = ye - 16'd1 + sy;
                pix_color = it.color;
                cols_left = (xe > xs) ? xe - xs : 16'd0;
                rows_left = (ye > ys) ? ye - ys : 16'd0;
                low_half  = 1'b0;
                load_byte(CMD_CASET, 1'b1);
                phase = PH_CASET;
            end

            // shift tick or chip-select-high gap
            if (phase != PH_IDLE) begin
                p.busy_res = 1'b1;
                if (tick_in_byte < BYTE_TICKS) begin
                    p.chip_select_n = 1'b0;
                    p.serial_clock  = tick_in_byte[0];
                    p.serial_data   = shreg[3'd7 - tick_in_byte[3:1]];
                    p.reg_select    = ~cmd_mode;
                    tick_in_byte    = tick_in_byte + 5'd1;
                end else begin
                    tick_in_byte = '0;
                    if (phase == PH_SINGLE) phase = PH_IDLE;
                    else advance();
                end
            end
            expected_pins.push_back(p);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task cmp_field(string name, logic got_bit, logic want_bit);
            if (got_bit !== want_bit)
                report($sformatf("result %0d %s got %b want %b",
                                 checked, name, got_bit, want_bit));
        endtask

        task check_pins(t_pins got);
            t_pins want;
            checked++;
            if (expected_pins.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", checked));
                return;
            end
            want = expected_pins.pop_front();
            cmp_field("chip_select_n", got.chip_select_n, want.chip_select_n);
            cmp_field("serial_clock",  got.serial_clock,  want.serial_clock);
            cmp_field("serial_data",   got.serial_data,   want.serial_data);
            cmp_field("reg_select",    got.reg_select,    want.reg_select);
            cmp_field("busy_res",      got.busy_res,      want.busy_res);
            cmp_field("rejected",      got.rejected,      want.rejected);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_index  = 1'b0;
    logic [7:0]  i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action     = '0;
    logic [15:0] i_x_start    = '0;
    logic [15:0] i_y_start    = '0;
    logic [15:0] i_x_end      = '0;
    logic [15:0] i_y_end      = '0;
    logic [15:0] i_color      = '0;
    logic [7:0]  i_byte_value = '0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_chip_select_n;
    logic        o_serial_clock;
    logic        o_serial_data;
    logic        o_reg_select;
    logic        o_busy_res;
    logic        o_rejected;

    pin_scoreboard sb = new();
    int            idle_pct   = 0;
    int            stall_left = 0;
    int            n_sent     = 0;

    spi_lcd_window_fill_engine_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .i_color         (i_color),
        .i_byte_value    (i_byte_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chip_select_n (o_chip_select_n),
        .o_serial_clock  (o_serial_clock),
        .o_serial_data   (o_serial_data),
        .o_reg_select    (o_reg_select),
        .o_busy_res      (o_busy_res),
        .o_rejected      (o_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // random idle burst length, zero when no idling is due
    function automatic int burst(int pct);
        if (pct == 0) return 0;
        if ($urandom_range(99) < pct) return $urandom_range(1, 15);
        return 0;
    endfunction

    function automatic t_item random_fields(logic [1:0] act);
        t_item it;
        it.action     = act;
        it.x_start    = 16'($urandom);
        it.y_start    = 16'($urandom);
        it.x_end      = 16'($urandom);
        it.y_end      = 16'($urandom);
        it.color      = 16'($urandom);
        it.byte_value = 8'($urandom);
        return it;
    endfunction

    function automatic t_item fill_item(logic [15:0] xs, logic [15:0] ys,
                                        logic [15:0] xe, logic [15:0] ye,
                                        logic [15:0] color);
        t_item it;
        it         = random_fields(ACT_FILL);
        it.x_start = xs;
        it.y_start = ys;
        it.x_end   = xe;
        it.y_end   = ye;
        it.color   = color;
        return it;
    endfunction

    // present one request and hold it until taken
    task automatic send_item(t_item it);
        int gap;
        @(negedge i_clk);
        gap = burst(idle_pct);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= it.action;
        i_x_start    <= it.x_start;
        i_y_start    <= it.y_start;
        i_x_end      <= it.x_end;
        i_y_end      <= it.y_end;
        i_color      <= it.color;
        i_byte_value <= it.byte_value;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(it);
        n_sent++;
    endtask

    // issue a request, then tick until the link is idle again
    task automatic run_request(t_item it, int noise_pct);
        t_item t;
        send_item(it);
        while (sb.phase != PH_IDLE) begin
            t = random_fields(ACT_TICK);
            if ($urandom_range(99) < noise_pct) t.action = 2'($urandom_range(1, 3));
            send_item(t);
        end
    endtask

    // stop requests and let every pending result drain
    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] orient, logic [7:0] off);
        quiesce();
        write_reg(CFG_ORIENTATION, {6'd0, orient});
        write_reg(CFG_OFFSET, off);
    endtask

    // result side back-pressure
    always @(negedge i_clk) begin : out_stall_gen
        int n;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            n = burst(idle_pct / 3);
            stall_left = (n > 0) ? n - 1 : 0;
            i_out_stall <= (n > 0);
        end
    end

    // check every taken result
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_pins({o_chip_select_n, o_serial_clock, o_serial_data,
                           o_reg_select, o_busy_res, o_rejected});
    end

    initial begin
        t_item       it;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // single bytes at the extremes, then a plain tick while idle
        it = random_fields(ACT_CMD);  it.byte_value = 8'h00; run_request(it, 0);
        it = random_fields(ACT_DATA); it.byte_value = 8'hFF; run_request(it, 0);
        run_request(random_fields(ACT_TICK), 0);

        // one column, two rows, column window wraps; sees requests while busy
        idle_pct = 35;
        run_request(fill_item(16'hFFF0, 16'd5, 16'hFFF1, 16'd7, 16'h8001), 30);

        // row offset with wrap, empty columns
        set_config(2'd2, 8'hFF);
        run_request(fill_item(16'd9, 16'hFF80, 16'd6, 16'hFF82, 16'h1234), 10);

        // column rotation with zero offset, empty rows, no idling from here on
        set_config(2'd1, 8'h00);
        idle_pct = 0;
        run_request(fill_item(16'd0, 16'd4, 16'd3, 16'd4, 16'hF00F), 10);

        // random single bytes and ticks up to the item count
        while (n_sent < 680) begin
            if ($urandom_range(99) < 85)
                it = random_fields($urandom_range(0, 1) ? ACT_CMD : ACT_DATA);
            else
                it = random_fields(ACT_TICK);
            run_request(it, 3);
        end

        quiesce();
        repeat (8) @(posedge i_clk);
        if (sb.expected_pins.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_pins.size()));
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
